// ----- rtl/ptg_pkg.sv -----
// Shared types, constants and codes of the pairwise threshold game scorer.
package ptg_pkg;

  localparam int MAX_MEMBERS_DEF    = 1024;
  localparam int MAX_DIMENSIONS_DEF = 16;

  localparam int COORD_W = 20;
  localparam int THR_W   = 20;
  localparam int PAY_W   = 16;
  localparam int SCORE_W = 32;
  localparam int CNT_W   = 20;
  localparam int IDX_W   = 10;
  localparam int MREG_W  = 11;
  localparam int DREG_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 96;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GENEROUS = 3'd0,
    REG_STRICT   = 3'd1,
    REG_BENEFIT  = 3'd2,
    REG_COST     = 3'd3,
    REG_MEMBERS  = 3'd4,
    REG_DIMS     = 3'd5
  } reg_idx_t;

  // Operation codes of an input beat.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Kinds of a result beat.
  typedef enum logic {
    KIND_ROUND = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  // Command passed from the front end to the scoring engine.
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Threshold and payoff settings used by the scoring engine.
  typedef struct packed {
    logic [THR_W-1:0] gen_thr;
    logic [THR_W-1:0] str_thr;
    logic [PAY_W-1:0] benefit;
    logic [PAY_W-1:0] cost;
  } game_cfg_t;

endpackage

// ----- rtl/ptg_queue.sv -----
// Two-entry command queue between the front end and the scoring engine.
module ptg_queue
  import ptg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slot[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  // Storage needs no reset; pointers and count do.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + 2'(push) - 2'(pop));
    end
  end

endmodule

// ----- rtl/ptg_front.sv -----
// Input front end: takes beats, tracks the load position and queues commands.
module ptg_front
  import ptg_pkg::*;
#(
  parameter int AW = 14,
  parameter int TW = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  op_t                in_op,
  input  logic [COORD_W-1:0] in_coord,
  input  logic               in_generous,
  input  logic [IDX_W-1:0]   in_idx,
  input  logic [TW-1:0]      total,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd,
  input  logic               round_done,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [COORD_W:0]   wr_data
);

  logic [TW-1:0] pos;
  logic [TW-1:0] pos_eff;
  logic [TW:0]   pos_inc;
  logic          last;
  logic          round_busy;
  logic          fire;

  // Loads wait while a round is pending, since the round reads the store.
  assign in_ready = !q_full && ((in_op == OP_READ) || !round_busy);
  assign fire     = in_valid && in_ready;

  // A stale position past the end starts a new round.
  assign pos_eff = (pos >= total) ? '0 : pos;
  assign pos_inc = (TW+1)'(pos_eff) + (TW+1)'(1);
  assign last    = (pos_inc >= (TW+1)'(total));

  assign wr_en   = fire && (in_op == OP_LOAD);
  assign wr_addr = pos_eff[AW-1:0];
  assign wr_data = {in_generous, in_coord};

  assign q_push     = fire && ((in_op == OP_READ) || last);
  assign q_cmd.op   = in_op;
  assign q_cmd.idx  = in_idx;

  // Load position and round-pending flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      round_busy <= 1'b0;
    end else begin
      if (wr_en) begin
        pos <= last ? '0 : pos_inc[TW-1:0];
      end
      if (wr_en && last) begin
        round_busy <= 1'b1;
      end else if (round_done) begin
        round_busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/ptg_back.sv -----
// Scoring engine: coordinate and score memories, the all-pairs pass and reads.
module ptg_back
  import ptg_pkg::*;
#(
  parameter int MAX_MEMBERS    = MAX_MEMBERS_DEF,
  parameter int MAX_DIMENSIONS = MAX_DIMENSIONS_DEF,
  parameter int AW = 14,
  parameter int MW = 11,
  parameter int DW = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  game_cfg_t             cfg,
  input  logic [MW-1:0]         members,
  input  logic [DW-1:0]         dims,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [COORD_W:0]      wr_data,
  input  cmd_t                  q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  round_done,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output kind_t                 out_kind
);

  localparam int DEPTH = MAX_MEMBERS * MAX_DIMENSIONS;
  localparam int IW    = $clog2(MAX_MEMBERS);
  localparam int SQ_W  = 2 * (COORD_W + 1);
  localparam int ACC_W = SQ_W + $clog2(MAX_DIMENSIONS + 1);
  localparam int THR2_W = 2 * THR_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_DATA, ST_START, ST_PAIR, ST_ISSUE, ST_DRAIN, ST_EVAL,
    ST_ROW_END, ST_DONE
  } state_t;

  state_t state;

  logic [COORD_W:0] coord_mem [DEPTH];
  logic [SCORE_W-1:0] score_mem [MAX_MEMBERS];

  logic [MW-1:0] i_cnt, j_cnt, filled;
  logic [DW-1:0] k_cnt;
  logic [AW-1:0] base_i, base_j;
  logic [AW-1:0] addr_a, addr_b;
  logic [COORD_W:0] rd_a, rd_b;
  logic          issue, issue_last;
  logic          p1_v, p1_last, p2_v, p2_last;
  logic [SQ_W-1:0]  sq;
  logic [ACC_W-1:0] acc;
  logic [THR2_W-1:0] g2, s2;
  logic          gi, gj;
  logic [SCORE_W-1:0] row_score;
  logic [CNT_W-1:0] coop, defect, duped;
  logic [SCORE_W-1:0] score_q;
  logic [IW-1:0] score_raddr;
  logic          idx_ok;
  logic          score_we;

  // Two coordinate reads a cycle, one write from the front end.
  assign addr_a     = AW'(base_i + AW'(k_cnt));
  assign addr_b     = AW'(base_j + AW'(k_cnt));
  assign issue      = (state == ST_ISSUE);
  assign issue_last = (k_cnt == DW'(dims - DW'(1)));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coord_mem[wr_addr] <= wr_data;
    end
    rd_a <= coord_mem[addr_a];
    rd_b <= coord_mem[addr_b];
  end

  // Score memory: written at the end of each row, read for score requests.
  assign score_raddr = IW'(q_head.idx);
  assign score_we    = (state == ST_ROW_END);

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[i_cnt[IW-1:0]] <= row_score;
    end
    score_q <= score_mem[score_raddr];
  end

  // Distance pipeline: read, difference squared, accumulate.
  logic signed [COORD_W:0] diff;
  logic signed [SQ_W-1:0]  prod;
  assign diff = $signed({rd_a[COORD_W-1], rd_a[COORD_W-1:0]}) -
                $signed({rd_b[COORD_W-1], rd_b[COORD_W-1:0]});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v;
    end
    p1_last <= issue_last;
    p2_last <= p1_last;
    sq      <= SQ_W'(prod);
    if (p1_v && p1_last) begin
      gi <= rd_a[COORD_W];
      gj <= rd_b[COORD_W];
    end
  end

  // Game outcome of the finished pair.
  logic [ACC_W-1:0] g2x, s2x;
  logic far, near, mid;
  logic [PAY_W+1:0] add;
  logic [SCORE_W:0] sum;
  logic coop_inc, defect_inc, dup_inc;

  assign g2x  = ACC_W'(g2);
  assign s2x  = ACC_W'(s2);
  assign far  = acc > g2x;
  assign near = acc < s2x;
  assign mid  = (acc > s2x) && (acc < g2x);

  always_comb begin
    add = '0;
    if (far) begin
      add = add + (PAY_W+2)'(cfg.cost);
    end
    if (near) begin
      add = add + (PAY_W+2)'(cfg.benefit);
    end
    if (mid) begin
      if (!gi && gj) begin
        add = add + (PAY_W+2)'(cfg.benefit) + (PAY_W+2)'(cfg.cost);
      end else if (gi && gj) begin
        add = add + (PAY_W+2)'(cfg.benefit);
      end else if (!gi && !gj) begin
        add = add + (PAY_W+2)'(cfg.cost);
      end
    end
  end

  assign sum        = (SCORE_W+1)'(row_score) + (SCORE_W+1)'(add);
  assign coop_inc   = near || (mid && gi && gj);
  assign defect_inc = far || (mid && !gi && !gj);
  assign dup_inc    = mid && (gi != gj);

  assign q_pop = (state == ST_IDLE) && !q_empty && !out_valid;

  // Control sequencer with output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      round_done <= 1'b0;
      filled     <= '0;
      coop       <= '0;
      defect     <= '0;
      duped      <= '0;
    end else begin
      round_done <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (p2_v) begin
        acc <= acc + ACC_W'(sq);
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            idx_ok <= (32'(q_head.idx) < MAX_MEMBERS) &&
                      (32'(q_head.idx) < 32'(filled));
            state  <= (q_head.op == OP_READ) ? ST_RD_DATA : ST_START;
          end
        end
        ST_RD_DATA: begin
          out_valid <= 1'b1;
          out_kind  <= KIND_READ;
          out_data  <= {duped, defect, coop, idx_ok ? score_q : '0};
          state     <= ST_IDLE;
        end
        ST_START: begin
          g2        <= THR2_W'(cfg.gen_thr) * THR2_W'(cfg.gen_thr);
          s2        <= THR2_W'(cfg.str_thr) * THR2_W'(cfg.str_thr);
          coop      <= '0;
          defect    <= '0;
          duped     <= '0;
          filled    <= '0;
          i_cnt     <= '0;
          j_cnt     <= '0;
          base_i    <= '0;
          base_j    <= '0;
          row_score <= '0;
          state     <= ST_PAIR;
        end
        ST_PAIR: begin
          if (j_cnt == members) begin
            state <= ST_ROW_END;
          end else if (j_cnt == i_cnt) begin
            j_cnt  <= MW'(j_cnt + MW'(1));
            base_j <= AW'(base_j + AW'(dims));
          end else begin
            k_cnt <= '0;
            acc   <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          k_cnt <= DW'(k_cnt + DW'(1));
          if (issue_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (p2_v && p2_last) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          row_score <= sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
          if (coop_inc && (coop != '1)) begin
            coop <= CNT_W'(coop + CNT_W'(1));
          end
          if (defect_inc && (defect != '1)) begin
            defect <= CNT_W'(defect + CNT_W'(1));
          end
          if (dup_inc && (duped != '1)) begin
            duped <= CNT_W'(duped + CNT_W'(1));
          end
          j_cnt  <= MW'(j_cnt + MW'(1));
          base_j <= AW'(base_j + AW'(dims));
          state  <= ST_PAIR;
        end
        ST_ROW_END: begin
          filled <= MW'(i_cnt + MW'(1));
          if (i_cnt == MW'(members - MW'(1))) begin
            state <= ST_DONE;
          end else begin
            i_cnt     <= MW'(i_cnt + MW'(1));
            base_i    <= AW'(base_i + AW'(dims));
            j_cnt     <= '0;
            base_j    <= '0;
            row_score <= '0;
            state     <= ST_PAIR;
          end
        end
        ST_DONE: begin
          out_valid  <= 1'b1;
          out_kind   <= KIND_ROUND;
          out_data   <= {duped, defect, coop, SCORE_W'(0)};
          round_done <= 1'b1;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pairwise_threshold_game_scorer.sv -----
// Top level of the pairwise threshold game scorer: configuration and wiring.
//
// The front end writes each load beat's coordinate to the store and moves
// on. The load that completes a round starts the all-pairs pass, which
// plays every ordered pair of distinct members: the coordinate pairs are
// read through the two read ports of the coordinate memory, then come a
// squaring stage, accumulation and the outcome step, and each row ends with
// a score write. Further loads wait until the round result is in the output
// register; score reads are queued and answered once they reach the engine.
module pairwise_threshold_game_scorer
  import ptg_pkg::*;
#(
  parameter int MAX_MEMBERS    = MAX_MEMBERS_DEF,
  parameter int MAX_DIMENSIONS = MAX_DIMENSIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // coordinate [19:0], is_generous [20], member_index [30:21], zero [31]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation [0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // member_score [31:0], mutual_coop_count [51:32],
  // mutual_defect_count [71:52], duped_count [91:72], zero [95:92]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // result_kind [0]
  output logic                  m_axis_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_MEMBERS * MAX_DIMENSIONS);
  localparam int TW = $clog2(MAX_MEMBERS * MAX_DIMENSIONS + 1);
  localparam int MW = $clog2(MAX_MEMBERS + 1);
  localparam int DW = $clog2(MAX_DIMENSIONS + 1);

  game_cfg_t         game_cfg;
  logic [MREG_W-1:0] members_reg;
  logic [DREG_W-1:0] dims_reg;
  logic [MW-1:0]     members;
  logic [DW-1:0]     dims;
  logic [TW-1:0]     total;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      game_cfg.gen_thr <= THR_W'(2560);
      game_cfg.str_thr <= THR_W'(256);
      game_cfg.benefit <= PAY_W'(10);
      game_cfg.cost    <= PAY_W'(1);
      members_reg      <= MREG_W'(1000);
      dims_reg         <= DREG_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GENEROUS: game_cfg.gen_thr <= cfg_data[THR_W-1:0];
        REG_STRICT:   game_cfg.str_thr <= cfg_data[THR_W-1:0];
        REG_BENEFIT:  game_cfg.benefit <= cfg_data[PAY_W-1:0];
        REG_COST:     game_cfg.cost    <= cfg_data[PAY_W-1:0];
        REG_MEMBERS:  members_reg      <= cfg_data[MREG_W-1:0];
        REG_DIMS:     dims_reg         <= cfg_data[DREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the member and dimension counts to the supported range.
  always_comb begin
    if (32'(members_reg) < 2) begin
      members = MW'(2);
    end else if (32'(members_reg) > MAX_MEMBERS) begin
      members = MW'(MAX_MEMBERS);
    end else begin
      members = MW'(members_reg);
    end
    if (32'(dims_reg) < 1) begin
      dims = DW'(1);
    end else if (32'(dims_reg) > MAX_DIMENSIONS) begin
      dims = DW'(MAX_DIMENSIONS);
    end else begin
      dims = DW'(dims_reg);
    end
  end

  assign total = TW'(members) * TW'(dims);

  logic             q_push, q_pop, q_full, q_empty;
  cmd_t             q_cmd, q_head;
  logic             round_done;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [COORD_W:0] wr_data;
  kind_t            out_kind;

  ptg_front #(
    .AW(AW),
    .TW(TW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (op_t'(s_axis_tuser)),
    .in_coord   (s_axis_tdata[19:0]),
    .in_generous(s_axis_tdata[20]),
    .in_idx     (s_axis_tdata[30:21]),
    .total      (total),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .round_done (round_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  ptg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  ptg_back #(
    .MAX_MEMBERS   (MAX_MEMBERS),
    .MAX_DIMENSIONS(MAX_DIMENSIONS),
    .AW            (AW),
    .MW            (MW),
    .DW            (DW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (game_cfg),
    .members   (members),
    .dims      (dims),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .round_done(round_done),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (out_kind)
  );

  assign m_axis_tuser = out_kind;

endmodule
